@@ rtl/scan_polar_to_cartesian_macros.svh @@
// assertion macros for the scan polar to cartesian checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// same-cycle implication, disabled during reset
`define SP2C_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SP2C_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/sp2c_pkg.sv @@
// shared types, constants and the arctangent table of the polar to cartesian block
// no dependencies
package sp2c_pkg;

    localparam int RANGE_BITS    = 16;
    localparam int PHASE_BITS    = 32;
    localparam int CORDIC_STAGES = 16;

    localparam int RANGE_W = 16;   // range_mm field width
    localparam int OUT_W   = 17;   // x_mm / y_mm field width
    localparam int XW      = 36;   // cordic x/y datapath width
    localparam int ZW      = 34;   // residual angle width
    localparam int SHW     = $clog2(CORDIC_STAGES);
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] GAIN_Q16  = 16'd39797;
    localparam int          OUT_LIMIT = 65535;

    localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((33'd1 << RANGE_BITS) - 33'd1);
    localparam logic [31:0]        PHASE_MASK = ~32'((33'd1 << (32 - PHASE_BITS)) - 33'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1
    } sp2c_cfg_idx_t;

    // one rotation vector moving down the cell chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } sp2c_vec_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
        logic [31:0] a;
        unique case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return $signed({{(ZW-32){1'b0}}, a});
    endfunction

endpackage

@@ rtl/sp2c_prep.sv @@
// entry cell: gain multiply and quadrant fold, one register stage
// depends on sp2c_pkg
module sp2c_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sp2c_pkg::RANGE_W-1:0]   range_mm,
    input  logic [31:0]                    phase,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sp2c_pkg::sp2c_vec_t            out_vec
);
    import sp2c_pkg::*;

    localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sh040000000);
    localparam logic signed [ZW-1:0] HALF    = ZW'(34'sh080000000);

    logic                 valid_reg;
    sp2c_vec_t            vec_reg;
    sp2c_vec_t            vec_next;
    logic [31:0]          ph;
    logic signed [ZW-1:0] z0;
    logic [31:0]          prod;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        ph   = phase & PHASE_MASK;
        z0   = $signed({{(ZW-32){ph[31]}}, ph});
        prod = 32'(range_mm & RANGE_MASK) * 32'(GAIN_Q16);
        vec_next.x    = $signed({{(XW-32){1'b0}}, prod});
        vec_next.y    = '0;
        vec_next.flip = 1'b0;
        vec_next.z    = z0;
        if (z0 > QUARTER)
        begin
            vec_next.z    = z0 - HALF;
            vec_next.flip = 1'b1;
        end
        else if (z0 < -QUARTER)
        begin
            vec_next.z    = z0 + HALF;
            vec_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ rtl/sp2c_cordic_cell.sv @@
// one cordic rotation cell with its own stage register
// depends on sp2c_pkg
module sp2c_cordic_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sp2c_pkg::SHW-1:0]       shift,
    input  logic signed [sp2c_pkg::ZW-1:0] atan_step,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sp2c_pkg::sp2c_vec_t            in_vec,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sp2c_pkg::sp2c_vec_t            out_vec
);
    import sp2c_pkg::*;

    logic                 valid_reg;
    sp2c_vec_t            vec_reg;
    sp2c_vec_t            vec_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = in_vec.y >>> shift;
        dy = in_vec.x >>> shift;
        vec_next.flip = in_vec.flip;
        if (!in_vec.z[ZW-1])
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - atan_step;
        end
        else
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ rtl/sp2c_post.sv @@
// exit cell: rounding, half-turn negate and saturation into the output register
// depends on sp2c_pkg
module sp2c_post (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sp2c_pkg::sp2c_vec_t          in_vec,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sp2c_pkg::OUT_W-1:0]   x_mm,
    output logic [sp2c_pkg::OUT_W-1:0]   y_mm
);
    import sp2c_pkg::*;

    localparam logic signed [XW-1:0] LIM  = XW'(OUT_LIMIT);
    localparam logic signed [XW-1:0] HALF = XW'(32768);

    logic               valid_reg;
    logic [OUT_W-1:0]   x_reg;
    logic [OUT_W-1:0]   y_reg;
    logic [OUT_W-1:0]   x_next;
    logic [OUT_W-1:0]   y_next;

    function automatic logic [OUT_W-1:0] finish(input logic signed [XW-1:0] v,
                                                input logic flip);
        logic signed [XW-1:0] r;
        r = (v + HALF) >>> 16;
        if (flip)
            r = -r;
        if (r > LIM)
            r = LIM;
        else if (r < -LIM)
            r = -LIM;
        return r[OUT_W-1:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_next = finish(in_vec.x, in_vec.flip);
        y_next = finish(in_vec.y, in_vec.flip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_mm      = x_reg;
    assign y_mm      = y_reg;

endmodule

@@ rtl/scan_polar_to_cartesian.sv @@
// path from input beat to output beat: entry cell register, rotation cell registers, output register
// throughput: one beat per cycle while m_tready is high; every cell of the rotation chain is a full stage
// and a stalled output backs up only as far as the chain holds no empty stage
// reset (rst_n, async, active low) clears start_angle, angle_step, beam angle
// and all stage valids; no clearing pass, the block takes beats right after reset
// top level: beam angle tracking, config registers, cell chain; needs sp2c_pkg
module scan_polar_to_cartesian (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,    // [15:0] range_mm
    input  logic [1:0]                      s_tuser,    // [0] no_return, [1] scan_start
    // point stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,    // [16:0] x_mm, [33:17] y_mm, rest 0
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sp2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import sp2c_pkg::*;

    logic [31:0] start_angle_reg;
    logic [31:0] angle_step_reg;
    logic [31:0] beam_angle_reg;
    logic [31:0] angle_cur;
    logic        s_beat;

    // chain handshake: index 0 is the entry cell, CORDIC_STAGES the last rotation
    logic        chain_valid [CORDIC_STAGES+1];
    logic        chain_ready [CORDIC_STAGES+1];
    sp2c_vec_t   chain_vec   [CORDIC_STAGES+1];
    logic        post_ready;

    logic [OUT_W-1:0] x_mm;
    logic [OUT_W-1:0] y_mm;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (sp2c_cfg_idx_t'(cfg_index))
                CFG_START_ANGLE: start_angle_reg <= cfg_data;
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                default: ;      // unknown index, write dropped
            endcase
        end
    end

    // angle for this beat: reload on scan start, step after every beat
    assign angle_cur = s_tuser[1] ? start_angle_reg : beam_angle_reg;
    assign s_beat    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beam_angle_reg <= '0;
        else if (s_beat)
            beam_angle_reg <= angle_cur + angle_step_reg;
    end

    // no-return beats are taken but enter the chain as a bubble
    sp2c_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && !s_tuser[0]),
        .in_ready  (s_tready),
        .range_mm  (s_tdata[RANGE_W-1:0]),
        .phase     (angle_cur),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    // one rotation cell per stage, shift and arctangent fixed per position
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        sp2c_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (SHW'(i)),
            .atan_step (atan_at(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // last cell feeds the output register
    assign chain_ready[CORDIC_STAGES] = post_ready;

    sp2c_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (post_ready),
        .in_vec    (chain_vec[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_mm      (x_mm),
        .y_mm      (y_mm)
    );

    assign m_tdata = {6'b0, y_mm, x_mm};

endmodule

@@ rtl/sp2c_checker.sv @@
// port-level checks on the polar to cartesian block, bound to the top level
// depends on scan_polar_to_cartesian_macros.svh
`include "scan_polar_to_cartesian_macros.svh"

module sp2c_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [39:0]                     m_tdata
);
    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    // stalled point beat holds its data
    `SP2C_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // saturation keeps both coordinates off the most negative code
    `SP2C_ASSERT_IMP(a_x_sat, m_tvalid, m_tdata[16:0] != 17'h10000, "x_mm past limit")
    `SP2C_ASSERT_IMP(a_y_sat, m_tvalid, m_tdata[33:17] != 17'h10000, "y_mm past limit")

    // byte padding stays zero
    `SP2C_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[39:34] == 6'b0, "tdata padding not zero")

endmodule

bind scan_polar_to_cartesian sp2c_checker u_checker (.*);

@@ sim/scan_polar_scoreboard.sv @@
// scoreboard for scan_polar_to_cartesian: watches the sample, point and register channels
// predicts every point with a fixed-point cordic of its own and compares; needs sp2c_pkg
module scan_polar_scoreboard (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,    // [15:0] range_mm
    input  logic [1:0]                      s_tuser,    // [0] no_return, [1] scan_start
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [39:0]                     m_tdata,    // [16:0] x_mm, [33:17] y_mm, rest 0
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sp2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output int                              mismatches,
    output int                              points_due,
    output int                              samples_seen,
    output int                              points_seen,
    output int                              writes_seen
);

    localparam int     ROT_STAGES   = 16;
    localparam int     TURN_TABLE_N = 24;
    localparam longint CORDIC_GAIN  = 39797;
    localparam longint COORD_MAX    = 65535;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam int     NO_RETURN_BIT  = 0;
    localparam int     SCAN_START_BIT = 1;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
    } point_t;

    // arctan(2^-i) in 2^-32 turn units
    longint arctan_turn [TURN_TABLE_N] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic [31:0] start_phase;
    logic [31:0] step_phase;
    logic [31:0] beam_phase;
    point_t      expected_points [$];
    point_t      want;
    point_t      got;

    function automatic point_t rotate_point(input logic [31:0] phase, input logic [15:0] range);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        point_t p;
        z    = longint'($signed(phase));
        flip = 1'b0;
        // fold the back half-plane onto the front one, negate at the end
        if (z > QUARTER_TURN)
        begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        x = longint'(range) * CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < ROT_STAGES && i < TURN_TABLE_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        if (x > COORD_MAX)  x = COORD_MAX;
        if (x < -COORD_MAX) x = -COORD_MAX;
        if (y > COORD_MAX)  y = COORD_MAX;
        if (y < -COORD_MAX) y = -COORD_MAX;
        p.x = x[16:0];
        p.y = y[16:0];
        return p;
    endfunction

    task automatic note_mismatch(input string what, input longint exp_val, input longint act_val);
        if (mismatches < 10)
            $display("point %0d %s mismatch: expected %0d, got %0d",
                     points_seen, what, exp_val, act_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_phase  = '0;
            step_phase   = '0;
            beam_phase   = '0;
            expected_points.delete();
            mismatches   = 0;
            points_due   = 0;
            samples_seen = 0;
            points_seen  = 0;
            writes_seen  = 0;
        end
        else
        begin
            // point beat first, so it never pairs with a sample taken on the same edge
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[16:0];
                got.y = m_tdata[33:17];
                if (expected_points.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("point beat with nothing pending: x %0d, y %0d", got.x, got.y);
                    mismatches++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x)
                        note_mismatch("x_mm", want.x, got.x);
                    if (got.y !== want.y)
                        note_mismatch("y_mm", want.y, got.y);
                    if (m_tdata[39:34] !== 6'd0)
                        note_mismatch("padding", 0, m_tdata[39:34]);
                end
                points_seen++;
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[SCAN_START_BIT])
                    beam_phase = start_phase;
                if (!s_tuser[NO_RETURN_BIT])
                    expected_points.insert(expected_points.size(),
                                           rotate_point(beam_phase, s_tdata));
                // angle moves on after every sample, echo or not
                beam_phase = beam_phase + step_phase;
                samples_seen++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sp2c_pkg::CFG_START_ANGLE: start_phase = cfg_data;
                    sp2c_pkg::CFG_ANGLE_STEP:  step_phase  = cfg_data;
                    default: ;
                endcase
                writes_seen++;
            end

            points_due = expected_points.size();
        end
    end

endmodule

@@ sim/tb_scan_polar_to_cartesian.sv @@
// testbench top for scan_polar_to_cartesian: clock, reset, stimulus and verdict
// needs sp2c_pkg, the block itself and scan_polar_scoreboard
module tb_scan_polar_to_cartesian;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int PIPE_LATENCY     = sp2c_pkg::CORDIC_STAGES + 8;  // nominal pipeline depth, with margin
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTINGS_N       = 6;
    localparam int RANDOM_PER_SETTING = 225;

    // register indexes that decode to nothing
    localparam logic [sp2c_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [sp2c_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // one degree of beam step as a binary phase
    localparam logic [31:0] ONE_DEGREE = 32'd11930465;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;    // [15:0] range_mm
    logic [1:0]                      s_tuser   = '0;    // [0] no_return, [1] scan_start
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [39:0]                     m_tdata;           // [16:0] x_mm, [33:17] y_mm, rest 0
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sp2c_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]                     cfg_data  = '0;

    int mismatches;
    int points_due;
    int samples_seen;
    int points_seen;
    int writes_seen;

    // percent of cycles each side holds off
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    scan_polar_to_cartesian DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scan_polar_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .points_due   (points_due),
        .samples_seen (samples_seen),
        .points_seen  (points_seen),
        .writes_seen  (writes_seen)
    );

    // point side back-pressure, re-rolled every cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // register write beat; starts and ends on a falling edge, caller drops cfg_valid
    task automatic write_register(input logic [sp2c_pkg::CFG_IDX_W-1:0] index,
                                  input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // sample beat; valid stays high into the next sample unless a gap is rolled
    task automatic send_sample(input logic [15:0] range_mm, input logic no_return,
                               input logic scan_start);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= range_mm;
        s_tuser  <= {scan_start, no_return};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // random scans: a start beat then a run of samples, a little noise on scan_start
    task automatic send_scans(input int count);
        int          sent;
        int          scan_len;
        int          pick;
        logic [15:0] range_mm;
        sent = 0;
        while (sent < count)
        begin
            scan_len = $urandom_range(4, 40);
            for (int k = 0; k < scan_len && sent < count; k++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       range_mm = 16'd0;
                    1:       range_mm = 16'hFFFF;
                    2:       range_mm = 16'($urandom_range(1, 255));
                    default: range_mm = 16'($urandom);
                endcase
                send_sample(range_mm, ($urandom_range(0, 99) < 15),
                            (k == 0) || ($urandom_range(0, 99) < 3));
                sent++;
            end
        end
    endtask

    // let the chain empty out; no-return samples enter it as bubbles with nothing due
    task automatic drain_points();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (points_due != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] start_val;
        logic [31:0] step_val;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int setting = 0; setting < SETTINGS_N; setting++)
        begin
            // idling pattern: sender-light, then receiver-light, then none
            case (setting / 2)
                0:
                begin
                    src_idle_pct  = 26;
                    sink_idle_pct = 66;
                end
                1:
                begin
                    src_idle_pct  = 66;
                    sink_idle_pct = 26;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            // angle settings, extremes first
            case (setting)
                0:
                begin
                    start_val = 32'h0000_0000;
                    step_val  = 32'h2000_0000;
                end
                1:
                begin
                    start_val = 32'h7FFF_FFFF;
                    step_val  = 32'h8000_0000;
                end
                2:
                begin
                    start_val = 32'h8000_0000;
                    step_val  = 32'h7FFF_FFFF;
                end
                3:
                begin
                    start_val = $urandom;
                    step_val  = ONE_DEGREE;
                end
                4:
                begin
                    start_val = $urandom;
                    step_val  = 32'h0000_0000;
                end
                default:
                begin
                    start_val = $urandom;
                    step_val  = $urandom;
                end
            endcase

            write_register(sp2c_pkg::CFG_START_ANGLE, start_val);
            write_register(sp2c_pkg::CFG_ANGLE_STEP, step_val);
            if (setting == 0)
            begin
                // writes to undecoded indexes must leave both angles alone
                write_register(CFG_SPARE_LO, 32'hDEAD_BEEF);
                write_register(CFG_SPARE_HI, 32'h1234_5678);
            end
            cfg_valid <= 1'b0;

            if (setting == 0)
            begin
                // eighth-turn steps walk every octant, both quarter-turn edges and the half turn
                send_sample(16'd0,     1'b0, 1'b1);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b0, 1'b0);   // phase wraps to zero
                send_sample(16'd1,     1'b0, 1'b1);
                // start and no echo together: reload, no point, angle still moves
                send_sample(16'd4321,  1'b1, 1'b1);
                send_sample(16'd1000,  1'b0, 1'b0);
                send_sample(16'd1000,  1'b1, 1'b0);
                send_sample(16'd1000,  1'b0, 1'b0);
                send_sample(16'h8000,  1'b0, 1'b1);
                send_sample(16'h5555,  1'b0, 1'b0);
                send_sample(16'hAAAA,  1'b0, 1'b0);
                send_sample(16'hFFFF,  1'b1, 1'b0);
                send_sample(16'd0,     1'b1, 1'b1);
                send_sample(16'd2,     1'b0, 1'b0);
            end

            send_scans(RANDOM_PER_SETTING);
            drain_points();
        end

        $display("run covered %0d samples and %0d register writes over %0d angle settings",
                 samples_seen, writes_seen, SETTINGS_N);
        $display("%0d points compared, %0d mismatches, %0d points never arrived",
                 points_seen, mismatches, points_due);
        if (mismatches == 0 && points_due == 0)
            $display("** scan_polar_to_cartesian: PASSED **");
        else
            $display("** scan_polar_to_cartesian: FAILED **");
        $finish;
    end

    // hard stop if a handshake hangs
    initial
    begin
        #2000000;
        $display("timeout waiting on a handshake");
        $display("** scan_polar_to_cartesian: FAILED **");
        $finish;
    end

endmodule
